// ===== rtl/rsq_pkg.sv =====
`default_nettype none
package rsq_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int POS_W = 24;
    localparam int ANG_W = 16;
    localparam int ALPHA_IN_W = 16;
    localparam int CNT_W = 17;
    localparam int IDX_W = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = 1;

    localparam logic [3:0] OP_RAD  = 4'd0;
    localparam logic [3:0] OP_SQR  = 4'd1;
    localparam logic [3:0] OP_DIVX = 4'd2;
    localparam logic [3:0] OP_DIVP = 4'd3;
    localparam logic [3:0] OP_CORR = 4'd4;
    localparam logic [3:0] OP_MX2T = 4'd5;
    localparam logic [3:0] OP_MXT  = 4'd6;
    localparam logic [3:0] OP_SFIN = 4'd7;
    localparam logic [3:0] OP_CFIN = 4'd8;
    localparam logic [3:0] OP_QMAP = 4'd9;
    localparam logic [3:0] OP_MWC  = 4'd10;
    localparam logic [3:0] OP_MHS  = 4'd11;
    localparam logic [3:0] OP_MWS  = 4'd12;
    localparam logic [3:0] OP_MHC  = 4'd13;
    localparam logic [3:0] OP_HCST = 4'd14;
    localparam logic [3:0] OP_OFFS = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] dsel;
    } t_uop;

    typedef struct packed {
        logic [IDX_W-1:0]        base;
        logic [7:0]              alpha;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] w;
        logic signed [POS_W-1:0] h;
        logic [1:0]              quad;
        logic [12:0]             rem;
    } t_quad;

endpackage
`default_nettype wire

// ===== rtl/rsq_if.sv =====
`default_nettype none
interface rsq_quad_if;
    import rsq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    start_batch;
    logic signed [POS_W-1:0] left_x;
    logic signed [POS_W-1:0] top_y;
    logic signed [POS_W-1:0] rect_width;
    logic signed [POS_W-1:0] rect_height;
    logic signed [ANG_W-1:0] angle_deg;
    logic signed [ALPHA_IN_W-1:0] alpha_raw;
    modport source(output valid, start_batch, left_x, top_y, rect_width, rect_height,
                   angle_deg, alpha_raw, input ready);
    modport sink(input valid, start_batch, left_x, top_y, rect_width, rect_height,
                 angle_deg, alpha_raw, output ready);
endinterface

interface rsq_vert_if;
    import rsq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    tex_u;
    logic                    tex_v;
    logic [7:0]              opacity;
    logic [IDX_W-1:0]        index_value;
    logic                    last;
    modport source(output valid, kind, pos_x, pos_y, tex_u, tex_v, opacity, index_value,
                   last, input ready);
    modport sink(input valid, kind, pos_x, pos_y, tex_u, tex_v, opacity, index_value,
                 last, output ready);
endinterface
`default_nettype wire

// ===== rtl/rotated_sprite_quad_expander_top.sv =====
// Rotated sprite quad expander.
// i_quad takes one sprite rectangle per word (valid/ready). o_vert gives,
// per drawn quad, four vertex words then six index words; last marks the
// tenth. Quads with clamped alpha zero, or that would pass the vertex limit,
// give no words; start_batch clears the vertex counter first.
// The front classifies each quad in the cycle it is accepted and queues it
// (two entries). The back computes sine and cosine and the four products on
// one shared 34x34 multiplier, 35 sequencer steps, then emits ten words from
// an output register, one per cycle when the receiver is ready.
// The back takes the next quad from the queue only after it has loaded the
// tenth word of the current one; skipped quads are taken, with no push,
// while the queue has room.
// A receiver stall holds the output word; the back stops, the queue fills
// and then i_quad.ready drops.
// Reset (synchronous, active low) clears the counter, queue and sequencer.
`default_nettype none
module rotated_sprite_quad_expander_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsq_quad_if.sink   i_quad,
    rsq_vert_if.source o_vert
);
    import rsq_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    t_quad push_data, pop_data;

    rsq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_quad       (i_quad),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    rsq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    rsq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_vert      (o_vert)
    );

endmodule
`default_nettype wire

// ===== rtl/rsq_front.sv =====
`default_nettype none
module rsq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsq_quad_if.sink      i_quad,
    output logic          o_push_valid,
    output rsq_pkg::t_quad o_push_data,
    input  logic          i_push_ready
);
    import rsq_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt, eff;
    logic             accept, keep;
    logic signed [ALPHA_IN_W-1:0] alpha_s;
    logic [7:0]       alpha8;
    logic [17:0]      a0;
    logic [14:0]      a1;
    logic [1:0]       quad;
    logic [12:0]      rem;

    assign i_quad.ready = i_push_ready;
    assign accept = i_quad.valid && i_push_ready;

    always_comb begin
        eff = i_quad.start_batch ? '0 : r_cnt;
        alpha_s = i_quad.alpha_raw;
        if (alpha_s > 16'sd255) begin
            alpha8 = 8'd255;
        end else begin
            alpha8 = alpha_s[7:0];
        end
        keep = (alpha_s > 16'sd0) &&
               (({1'b0, eff} + 18'd4) <= 18'(MAX_VERTICES));

        a0 = 18'($signed({{2{i_quad.angle_deg[ANG_W-1]}}, i_quad.angle_deg})) + 18'd46080;
        if (a0 >= 18'd69120) begin
            a1 = 15'(a0 - 18'd69120);
        end else if (a0 >= 18'd46080) begin
            a1 = 15'(a0 - 18'd46080);
        end else if (a0 >= 18'd23040) begin
            a1 = 15'(a0 - 18'd23040);
        end else begin
            a1 = 15'(a0);
        end
        if (a1 >= 15'd17280) begin
            quad = 2'd3;
            rem = 13'(a1 - 15'd17280);
        end else if (a1 >= 15'd11520) begin
            quad = 2'd2;
            rem = 13'(a1 - 15'd11520);
        end else if (a1 >= 15'd5760) begin
            quad = 2'd1;
            rem = 13'(a1 - 15'd5760);
        end else begin
            quad = 2'd0;
            rem = 13'(a1);
        end

        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = keep ? CNT_W'(eff + CNT_W'(4)) : eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_push_valid = accept && keep;
    assign o_push_data.base = eff[IDX_W-1:0];
    assign o_push_data.alpha = alpha8;
    assign o_push_data.x = i_quad.left_x;
    assign o_push_data.y = i_quad.top_y;
    assign o_push_data.w = i_quad.rect_width;
    assign o_push_data.h = i_quad.rect_height;
    assign o_push_data.quad = quad;
    assign o_push_data.rem = rem;

endmodule
`default_nettype wire

// ===== rtl/rsq_fifo.sv =====
`default_nettype none
module rsq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  rsq_pkg::t_quad i_push_data,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output rsq_pkg::t_quad o_pop_data,
    input  logic           i_pop_ready
);
    import rsq_pkg::*;

    t_quad              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               push, pop;

    assign o_push_ready = (r_cnt != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rsq_back.sv =====
`default_nettype none
module rsq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  rsq_pkg::t_quad i_pop_data,
    output logic           o_pop_ready,
    rsq_vert_if.source     o_vert
);
    import rsq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [5:0] LAST_STEP = 6'd34;
    localparam logic [3:0] LAST_RES = 4'd9;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] RAD_Q30 = 34'sd292818;
    localparam logic [6:0]  DIV_D [9] = '{7'd72, 7'd42, 7'd20, 7'd6, 7'd90,
                                          7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [32:0] DIV_M [9] = '{
        33'((64'd1 << 33) / 72), 33'((64'd1 << 33) / 42), 33'((64'd1 << 33) / 20),
        33'((64'd1 << 33) / 6),  33'((64'd1 << 33) / 90), 33'((64'd1 << 33) / 56),
        33'((64'd1 << 33) / 30), 33'((64'd1 << 33) / 12), 33'((64'd1 << 33) / 2)};

    function automatic t_uop uop_at(input logic [5:0] s);
        t_uop u;
        u.dsel = '0;
        case (s)
            6'd0:  u.op = OP_RAD;
            6'd1:  u.op = OP_SQR;
            6'd2:  begin u.op = OP_DIVX; u.dsel = 4'd0; end
            6'd3:  begin u.op = OP_CORR; u.dsel = 4'd0; end
            6'd4:  u.op = OP_MX2T;
            6'd5:  begin u.op = OP_DIVP; u.dsel = 4'd1; end
            6'd6:  begin u.op = OP_CORR; u.dsel = 4'd1; end
            6'd7:  u.op = OP_MX2T;
            6'd8:  begin u.op = OP_DIVP; u.dsel = 4'd2; end
            6'd9:  begin u.op = OP_CORR; u.dsel = 4'd2; end
            6'd10: u.op = OP_MX2T;
            6'd11: begin u.op = OP_DIVP; u.dsel = 4'd3; end
            6'd12: begin u.op = OP_CORR; u.dsel = 4'd3; end
            6'd13: u.op = OP_MXT;
            6'd14: begin u.op = OP_SFIN; u.dsel = 4'd4; end
            6'd15: begin u.op = OP_CORR; u.dsel = 4'd4; end
            6'd16: u.op = OP_MX2T;
            6'd17: begin u.op = OP_DIVP; u.dsel = 4'd5; end
            6'd18: begin u.op = OP_CORR; u.dsel = 4'd5; end
            6'd19: u.op = OP_MX2T;
            6'd20: begin u.op = OP_DIVP; u.dsel = 4'd6; end
            6'd21: begin u.op = OP_CORR; u.dsel = 4'd6; end
            6'd22: u.op = OP_MX2T;
            6'd23: begin u.op = OP_DIVP; u.dsel = 4'd7; end
            6'd24: begin u.op = OP_CORR; u.dsel = 4'd7; end
            6'd25: u.op = OP_MX2T;
            6'd26: begin u.op = OP_DIVP; u.dsel = 4'd8; end
            6'd27: begin u.op = OP_CFIN; u.dsel = 4'd8; end
            6'd28: u.op = OP_QMAP;
            6'd29: u.op = OP_MWC;
            6'd30: u.op = OP_MHS;
            6'd31: u.op = OP_MWS;
            6'd32: u.op = OP_MHC;
            6'd33: u.op = OP_HCST;
            default: u.op = OP_OFFS;
        endcase
        return u;
    endfunction

    function automatic logic signed [16:0] q30_to_q15(input logic signed [33:0] v);
        logic [33:0] t;
        logic [18:0] r;
        t = (v < 0) ? '0 : v;
        r = 19'((t + 34'd16384) >> 15);
        if (r > 19'd32768) begin
            r = 19'd32768;
        end
        return $signed(r[16:0]);
    endfunction

    function automatic logic signed [POS_W-1:0] to_pos(input logic signed [43:0] v);
        logic signed [44:0] t;
        logic signed [28:0] r;
        t = 45'(v) + 45'sd32768;
        r = 29'(t >>> 16);
        if (r > 29'sd8388607) begin
            return 24'sd8388607;
        end else if (r < -29'sd8388608) begin
            return -24'sd8388608;
        end
        return r[POS_W-1:0];
    endfunction

    logic [1:0]  r_state;
    logic [5:0]  r_step;
    logic [3:0]  r_k;
    t_quad       r_q;
    logic signed [67:0] r_p;
    logic [32:0] r_x, r_x2, r_v;
    logic signed [33:0] r_t;
    logic signed [16:0] r_s, r_c, r_sn, r_cs;
    logic signed [43:0] r_wc, r_hs, r_ws, r_hc, r_cx, r_cy, r_dx0, r_dy0, r_dx1, r_dy1;

    logic        r_ov;
    logic        r_kind, r_tu, r_tv, r_last;
    logic signed [POS_W-1:0] r_px, r_py;
    logic [7:0]  r_op;
    logic [IDX_W-1:0] r_idx;

    t_uop        u;
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic [32:0] pv, q0, qc;
    logic [39:0] qd, rm;
    logic [6:0]  dd;
    logic        load;
    logic signed [43:0] vx, vy;
    logic [1:0]  ioff;
    logic signed [25:0] sx, sy;

    assign u = uop_at(r_step);
    assign pv = r_p[62:30];
    assign dd = DIV_D[u.dsel];
    assign q0 = r_p[65:33];
    assign qd = 40'(q0) * 40'(dd);
    assign rm = 40'(r_v) - qd;
    assign qc = (rm >= 40'(dd)) ? q0 + 33'd1 : q0;
    assign sx = $signed({r_q.x[POS_W-1], r_q.x, 1'b0}) + 26'(r_q.w);
    assign sy = $signed({r_q.y[POS_W-1], r_q.y, 1'b0}) + 26'(r_q.h);

    always_comb begin
        ma = '0;
        mb = '0;
        case (u.op)
            OP_RAD:  begin ma = $signed({21'b0, r_q.rem}); mb = RAD_Q30; end
            OP_SQR:  begin ma = $signed({1'b0, r_p[32:0]}); mb = $signed({1'b0, r_p[32:0]}); end
            OP_DIVX, OP_DIVP: begin
                ma = $signed({1'b0, pv});
                mb = $signed({1'b0, DIV_M[u.dsel]});
            end
            OP_MX2T: begin ma = $signed({1'b0, r_x2}); mb = r_t; end
            OP_MXT:  begin ma = $signed({1'b0, r_x}); mb = r_t; end
            OP_SFIN: begin ma = $signed({1'b0, r_x2}); mb = $signed({1'b0, DIV_M[u.dsel]}); end
            OP_MWC:  begin ma = 34'(r_q.w); mb = 34'(r_cs); end
            OP_MHS:  begin ma = 34'(r_q.h); mb = 34'(r_sn); end
            OP_MWS:  begin ma = 34'(r_q.w); mb = 34'(r_sn); end
            OP_MHC:  begin ma = 34'(r_q.h); mb = 34'(r_cs); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
    end

    always_comb begin
        case (r_k[1:0])
            2'd0:    begin vx = r_cx + r_dx0; vy = r_cy + r_dy0; end
            2'd1:    begin vx = r_cx + r_dx1; vy = r_cy + r_dy1; end
            2'd2:    begin vx = r_cx - r_dx0; vy = r_cy - r_dy0; end
            default: begin vx = r_cx - r_dx1; vy = r_cy - r_dy1; end
        endcase
        case (r_k)
            4'd4:    ioff = 2'd0;
            4'd5:    ioff = 2'd1;
            4'd6:    ioff = 2'd2;
            4'd7:    ioff = 2'd0;
            4'd8:    ioff = 2'd2;
            4'd9:    ioff = 2'd3;
            default: ioff = r_k[1:0];
        endcase
    end

    assign o_pop_ready = (r_state == ST_IDLE);
    assign load = (r_state == ST_EMIT) && (!r_ov || o_vert.ready);

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_q <= i_pop_data;
        end
        if (r_state == ST_CALC) begin
            r_p <= prod;
            case (u.op)
                OP_SQR:  r_x <= r_p[32:0];
                OP_DIVX: begin r_x2 <= pv; r_v <= pv; end
                OP_DIVP: r_v <= pv;
                OP_CORR: r_t <= ONE_Q30 - $signed({1'b0, qc});
                OP_SFIN: begin r_s <= q30_to_q15(r_p[63:30]); r_v <= r_x2; end
                OP_CFIN: r_c <= q30_to_q15(ONE_Q30 - $signed({1'b0, qc}));
                OP_QMAP: begin
                    case (r_q.quad)
                        2'd0:    begin r_sn <= r_s;  r_cs <= r_c;  end
                        2'd1:    begin r_sn <= r_c;  r_cs <= -r_s; end
                        2'd2:    begin r_sn <= -r_s; r_cs <= -r_c; end
                        default: begin r_sn <= -r_c; r_cs <= r_s;  end
                    endcase
                end
                OP_MHS:  r_wc <= r_p[43:0];
                OP_MWS:  r_hs <= r_p[43:0];
                OP_MHC:  r_ws <= r_p[43:0];
                OP_HCST: r_hc <= r_p[43:0];
                OP_OFFS: begin
                    r_cx <= 44'(sx) <<< 15;
                    r_cy <= 44'(sy) <<< 15;
                    r_dx0 <= r_hs - r_wc;
                    r_dy0 <= -r_ws - r_hc;
                    r_dx1 <= r_wc + r_hs;
                    r_dy1 <= r_ws - r_hc;
                end
                default: ;
            endcase
        end
        if (load) begin
            r_idx <= r_q.base + IDX_W'(ioff);
            r_last <= (r_k == LAST_RES);
            if (r_k < 4'd4) begin
                r_kind <= 1'b0;
                r_px <= to_pos(vx);
                r_py <= to_pos(vy);
                r_tu <= r_k[0] ^ r_k[1];
                r_tv <= r_k[1];
                r_op <= r_q.alpha;
            end else begin
                r_kind <= 1'b1;
                r_px <= '0;
                r_py <= '0;
                r_tu <= 1'b0;
                r_tv <= 1'b0;
                r_op <= '0;
            end
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_k <= '0;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_vert.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_state <= ST_CALC;
                        r_step <= '0;
                    end
                end
                ST_CALC: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_EMIT;
                        r_k <= '0;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                ST_EMIT: begin
                    if (load) begin
                        r_k <= r_k + 4'd1;
                        if (r_k == LAST_RES) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_vert.valid = r_ov;
    assign o_vert.kind = r_kind;
    assign o_vert.pos_x = r_px;
    assign o_vert.pos_y = r_py;
    assign o_vert.tex_u = r_tu;
    assign o_vert.tex_v = r_tv;
    assign o_vert.opacity = r_op;
    assign o_vert.index_value = r_idx;
    assign o_vert.last = r_last;

endmodule
`default_nettype wire

// ===== rtl/rsq_checker.sv =====
`default_nettype none
module rsq_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic                    i_kind,
    input logic                    i_last,
    input logic signed [23:0]      i_pos_x,
    input logic signed [23:0]      i_pos_y,
    input logic [7:0]              i_opacity
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid) else $error("output word dropped while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_kind) else $error("last on a vertex word");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind |-> i_pos_x == 0 && i_pos_y == 0 && i_opacity == 0)
        else $error("index word carries vertex data");

    a_vert_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_kind |-> i_opacity != 0) else $error("vertex word with zero opacity");

endmodule

bind rotated_sprite_quad_expander_top rsq_checker u_rsq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_vert.valid),
    .i_ready   (o_vert.ready),
    .i_kind    (o_vert.kind),
    .i_last    (o_vert.last),
    .i_pos_x   (o_vert.pos_x),
    .i_pos_y   (o_vert.pos_y),
    .i_opacity (o_vert.opacity)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    import rsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    tex_u;
        logic                    tex_v;
        logic [7:0]              opacity;
        logic [IDX_W-1:0]        index_value;
        logic                    last;
    } vert_word_t;

    typedef struct packed {
        logic                    start_batch;
        logic signed [POS_W-1:0] left_x;
        logic signed [POS_W-1:0] top_y;
        logic signed [POS_W-1:0] rect_width;
        logic signed [POS_W-1:0] rect_height;
        logic signed [ANG_W-1:0] angle_deg;
        logic signed [ALPHA_IN_W-1:0] alpha_raw;
    } quad_word_t;

    typedef struct {
        quad_word_t q;
        logic       has_exp;
        vert_word_t exp0;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rsq_quad_if quad_bus ();
    rsq_vert_if vert_bus ();

    rotated_sprite_quad_expander_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quad (quad_bus.sink),
        .o_vert (vert_bus.source)
    );

    always #6 i_clk = ~i_clk;

    vert_word_t  pending_verts[$];
    logic [16:0] vtx_count;
    int          n_errors;
    int          n_words;
    int          n_quads;
    int          n_drawn;
    int          last_at;
    int          src_idle_pct;
    int          snk_idle_pct;
    bit          hold_off;

    function automatic void trig_q15(input logic signed [15:0] ang,
                                     output longint s_o, output longint c_o);
        longint a, q, r, s, c, v;
        longint unsigned x, x2, t, u;
        a = ang % 23040;
        if (a < 0) a += 23040;
        q = a / 5760;
        r = a % 5760;
        x = r * 64'd292818;
        x2 = (x * x) >> 30;
        t = 64'd1073741824 - x2 / 72;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        v = longint'((x * t) >> 30);
        if (v < 0) v = 0;
        s = (v + 16384) >>> 15;
        if (s > 32768) s = 32768;
        u = 64'd1073741824 - x2 / 90;
        u = 64'd1073741824 - ((x2 * u) >> 30) / 56;
        u = 64'd1073741824 - ((x2 * u) >> 30) / 30;
        u = 64'd1073741824 - ((x2 * u) >> 30) / 12;
        v = 64'sd1073741824 - longint'(((x2 * u) >> 30) / 2);
        if (v < 0) v = 0;
        c = (v + 16384) >>> 15;
        if (c > 32768) c = 32768;
        case (q)
            0: begin s_o = s; c_o = c; end
            1: begin s_o = c; c_o = -s; end
            2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endfunction

    function automatic logic [23:0] round_pos(input longint v);
        longint t, r;
        t = v + 32768;
        r = (t >= 0) ? (t >>> 16) : -(((-t) + 65535) >>> 16);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    task automatic expand_quad(input quad_word_t q);
        longint alpha, x, y, w, h, s, c, cx, cy, dx0, dy0, dx1, dy1;
        longint px[4], py[4];
        int ix[6];
        logic [16:0] base;
        vert_word_t vw;
        ix = '{0, 1, 2, 0, 2, 3};
        if (q.start_batch) vtx_count = '0;
        alpha = q.alpha_raw;
        if (alpha > 255) alpha = 255;
        if (alpha <= 0) return;
        if (vtx_count + 4 > MAX_VERTICES) return;
        x = q.left_x; y = q.top_y; w = q.rect_width; h = q.rect_height;
        trig_q15(q.angle_deg, s, c);
        cx = (2 * x + w) * 32768;
        cy = (2 * y + h) * 32768;
        dx0 = -w * c + h * s;
        dy0 = -w * s - h * c;
        dx1 = w * c + h * s;
        dy1 = w * s - h * c;
        px = '{cx + dx0, cx + dx1, cx - dx0, cx - dx1};
        py = '{cy + dy0, cy + dy1, cy - dy0, cy - dy1};
        base = vtx_count;
        last_at = pending_verts.size();
        for (int k = 0; k < 4; k++) begin
            vw = '0;
            vw.pos_x = round_pos(px[k]);
            vw.pos_y = round_pos(py[k]);
            vw.tex_u = (k == 1 || k == 2);
            vw.tex_v = (k >= 2);
            vw.opacity = alpha[7:0];
            vw.index_value = 16'(base + k);
            pending_verts.push_back(vw);
        end
        for (int k = 0; k < 6; k++) begin
            vw = '0;
            vw.kind = 1'b1;
            vw.index_value = 16'(base + ix[k]);
            vw.last = (k == 5);
            pending_verts.push_back(vw);
        end
        vtx_count = 17'(base + 4);
        n_drawn++;
    endtask

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && vert_bus.valid && vert_bus.ready) begin
            vert_word_t e;
            n_words++;
            if (pending_verts.size() == 0) begin
                $error("unexpected word: index_value %0d", vert_bus.index_value);
                n_errors++;
            end else begin
                e = pending_verts.pop_front();
                check_field("kind", e.kind, vert_bus.kind);
                check_field("pos_x", e.pos_x, vert_bus.pos_x);
                check_field("pos_y", e.pos_y, vert_bus.pos_y);
                check_field("tex_u", e.tex_u, vert_bus.tex_u);
                check_field("tex_v", e.tex_v, vert_bus.tex_v);
                check_field("opacity", e.opacity, vert_bus.opacity);
                check_field("index_value", e.index_value, vert_bus.index_value);
                check_field("last", e.last, vert_bus.last);
            end
        end
    end

    initial vert_bus.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            vert_bus.ready <= 1'b0;
        else
            vert_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_quad(input quad_word_t q);
        while ($urandom_range(99) < src_idle_pct) begin
            quad_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        quad_bus.valid       <= 1'b1;
        quad_bus.start_batch <= q.start_batch;
        quad_bus.left_x      <= q.left_x;
        quad_bus.top_y       <= q.top_y;
        quad_bus.rect_width  <= q.rect_width;
        quad_bus.rect_height <= q.rect_height;
        quad_bus.angle_deg   <= q.angle_deg;
        quad_bus.alpha_raw   <= q.alpha_raw;
        do @(posedge i_clk); while (!quad_bus.ready);
        expand_quad(q);
        n_quads++;
    endtask

    function automatic quad_word_t rand_quad();
        quad_word_t q;
        int sel;
        q.start_batch = ($urandom_range(19) == 0);
        sel = $urandom_range(9);
        q.left_x = (sel == 0) ? 24'($urandom()) : 24'($urandom_range(40000) - 20000);
        q.top_y = (sel == 1) ? 24'($urandom()) : 24'($urandom_range(40000) - 20000);
        q.rect_width = (sel == 2) ? 24'($urandom()) : 24'($urandom_range(20000) - 4000);
        q.rect_height = (sel == 3) ? 24'($urandom()) : 24'($urandom_range(20000) - 4000);
        q.angle_deg = 16'($urandom());
        case ($urandom_range(9))
            0: q.alpha_raw = 16'($urandom());
            1: q.alpha_raw = -$signed(16'($urandom_range(3)));
            default: q.alpha_raw = 16'($urandom_range(400, 1));
        endcase
        return q;
    endfunction

    stim_row_t dir_rows[$];

    task automatic add_row(input quad_word_t q, input bit chk, input vert_word_t e);
        stim_row_t r;
        r.q = q; r.has_exp = chk; r.exp0 = e;
        dir_rows.push_back(r);
    endtask

    function automatic quad_word_t mk(input bit sb, input int x, input int y, input int w,
                                      input int h, input int a, input int al);
        quad_word_t q;
        q.start_batch = sb; q.left_x = 24'(x); q.top_y = 24'(y); q.rect_width = 24'(w);
        q.rect_height = 24'(h); q.angle_deg = 16'(a); q.alpha_raw = 16'(al);
        return q;
    endfunction

    initial begin
        quad_word_t q;
        vert_word_t e;
        int guard;
        n_errors = 0; n_words = 0; n_quads = 0; n_drawn = 0; last_at = 0;
        vtx_count = '0; hold_off = 1'b0;
        src_idle_pct = 0; snk_idle_pct = 0;
        quad_bus.valid = 1'b0; quad_bus.start_batch = 1'b0;
        quad_bus.left_x = '0; quad_bus.top_y = '0; quad_bus.rect_width = '0;
        quad_bus.rect_height = '0; quad_bus.angle_deg = '0; quad_bus.alpha_raw = '0;

        e = '0; e.pos_x = 24'sd256; e.pos_y = 24'sd512; e.opacity = 8'd255;
        add_row(mk(1, 256, 512, 1024, 1024, 0, 32767), 1, e);
        e = '0; e.pos_x = '0; e.pos_y = '0; e.opacity = 8'd1; e.index_value = 16'd4;
        add_row(mk(0, 0, 0, 0, 0, 0, 1), 1, e);
        add_row(mk(0, 0, 0, 100, 100, 0, 0), 0, e);
        add_row(mk(0, 0, 0, 100, 100, 0, -32768), 0, e);
        e = '0; e.pos_x = 24'h800000; e.pos_y = 24'h800000; e.opacity = 8'd255;
        add_row(mk(1, -8388608, -8388608, 1000, 1000, 0, 255), 1, e);
        e = '0; e.pos_x = 24'h7FFFFF; e.pos_y = 24'h7FFFFF; e.opacity = 8'd128;
        e.index_value = 16'd4;
        add_row(mk(0, 8388607, 8388607, 8388607, 8388607, 32767, 128), 1, e);
        add_row(mk(0, 8388607, -8388608, -8388608, 8388607, -32768, 256), 0, e);
        add_row(mk(0, -8388608, 8388607, -8388608, -8388608, 5760, 200), 0, e);
        add_row(mk(0, 1000, 1000, 2000, 3000, 11520, 50), 0, e);
        add_row(mk(0, 1000, 1000, 2000, 3000, 17280, 50), 0, e);
        add_row(mk(0, 1000, 1000, 2000, 3000, 23040, 50), 0, e);
        add_row(mk(0, 1000, 1000, 2000, 3000, -5760, 50), 0, e);
        add_row(mk(0, 1000, 1000, -2000, -3000, 2880, 254), 0, e);
        add_row(mk(0, -1, -1, 1, 1, 1, 300), 0, e);
        add_row(mk(0, 5000, -5000, 777, 333, 12345, 17), 0, e);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp && pending_verts.size() == 0) begin
                vtx_count_peek: begin
                    quad_word_t tq;
                    tq = dir_rows[i].q;
                    if (tq.start_batch) e = dir_rows[i].exp0;
                end
            end
            if (dir_rows[i].has_exp) begin
                int d0;
                d0 = n_drawn;
                send_quad(dir_rows[i].q);
                if (n_drawn > d0) begin
                    e = dir_rows[i].exp0;
                    check_field("directed pos_x", e.pos_x, pending_verts[last_at].pos_x);
                    check_field("directed pos_y", e.pos_y, pending_verts[last_at].pos_y);
                    check_field("directed opacity", e.opacity,
                                pending_verts[last_at].opacity);
                    check_field("directed index_value", e.index_value,
                                pending_verts[last_at].index_value);
                end else begin
                    $error("directed row %0d: no words predicted", i);
                    n_errors++;
                end
            end else begin
                send_quad(dir_rows[i].q);
            end
        end

        for (int i = 0; i < 420; i++) begin
            if (i < 140) begin src_idle_pct = 14; snk_idle_pct = 56; end
            else if (i < 280) begin src_idle_pct = 56; snk_idle_pct = 14; end
            else begin src_idle_pct = 0; snk_idle_pct = 0; end
            if (i == 300) hold_off = 1'b1;
            if (i == 200) begin
                q = mk(1, 0, 0, 256, 256, 0, 10);
                send_quad(q);
            end
            q = rand_quad();
            if (i >= 200 && i < 220) q.start_batch = 1'b0;
            send_quad(q);
        end
        quad_bus.valid <= 1'b0;

        guard = 0;
        while (pending_verts.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        $display("quads sent %0d, drawn %0d, words checked %0d", n_quads, n_drawn, n_words);
        $display("covered skips, batch restarts, saturation, full-angle range, long stall");
        if (n_errors == 0 && pending_verts.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        wait (hold_off);
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #15ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
